>>> src/pcft_pkg.sv
// pcft_pkg: shared constants, register indexes and types for the
// pulse-count frame transmitter. No dependencies.
`timescale 1ns / 1ps

package pcft_pkg;

    localparam int PAYLOAD_BYTES = 4;
    localparam int IN_BYTES      = 4;
    localparam int PAYLOAD_W     = 32;
    localparam int FRAME_BITS    = 8 * (PAYLOAD_BYTES + 1);
    localparam int BITS_W        = $clog2(FRAME_BITS + 1);
    localparam int CRC_CNT_W     = $clog2(PAYLOAD_BYTES + 1);

    localparam int PULSE_W = 8;
    localparam int GAP_W   = 10;
    localparam int LEAD_W  = 10;
    localparam int TAIL_W  = 12;
    localparam int CNT_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [PULSE_W-1:0] START_PULSES_RST = 8'd32;
    localparam logic [PULSE_W-1:0] ONE_PULSES_RST   = 8'd18;
    localparam logic [PULSE_W-1:0] ZERO_PULSES_RST  = 8'd9;
    localparam logic [GAP_W-1:0]   GAP_TICKS_RST    = 10'd20;
    localparam logic [LEAD_W-1:0]  LEAD_TICKS_RST   = 10'd4;
    localparam logic [TAIL_W-1:0]  TAIL_TICKS_RST   = 12'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_PULSES = 3'd0,
        REG_ONE_PULSES   = 3'd1,
        REG_ZERO_PULSES  = 3'd2,
        REG_GAP_TICKS    = 3'd3,
        REG_LEAD_TICKS   = 3'd4,
        REG_TAIL_TICKS   = 3'd5
    } t_cfg_reg;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic                 start;
        logic [PAYLOAD_W-1:0] payload;
    } t_crc_ctrl;

endpackage

>>> src/pulse_count_frame_transmitter_unit.sv
// pulse_count_frame_transmitter_unit: top level, frame sequencer, config
// registers and result register. Depends on pcft_pkg and pcft_crc.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------
//  in      | in        | i_in_valid / o_in_stall  | i_kind, i_payload
//  out     | out       | o_out_valid / i_out_stall| o_line, o_power_on, o_busy_res,
//          |           |                          | o_load_taken, o_frame_done
//  cfg     | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One beat per clock while the output is not stalled; each input beat yields one registered result beat.
// The CRC byte is computed after a load, long before the sequencer reaches the
// CRC bits.
// Input stalls only while a result is held and the output is stalled.
// Synchronous active-low reset; config registers return to defaults.
`timescale 1ns / 1ps

module pulse_count_frame_transmitter_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_kind,
    input  logic [pcft_pkg::PAYLOAD_W-1:0]     i_payload,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_line,
    output logic                               o_power_on,
    output logic                               o_busy_res,
    output logic                               o_load_taken,
    output logic                               o_frame_done,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pcft_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcft_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pcft_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEAD, PH_BURST, PH_GAP, PH_TAIL
    } t_phase;

    logic [PULSE_W-1:0] r_start_pulses, r_one_pulses, r_zero_pulses;
    logic [GAP_W-1:0]   r_gap_ticks;
    logic [LEAD_W-1:0]  r_lead_ticks;
    logic [TAIL_W-1:0]  r_tail_ticks;

    t_phase               r_phase, n_phase;
    logic [BITS_W-1:0]    r_bits_left, n_bits_left;
    logic [PULSE_W-1:0]   r_pulses_left, n_pulses_left;
    logic                 r_half_high, n_half_high;
    logic [CNT_W-1:0]     r_gap_count, n_gap_count;
    logic [PAYLOAD_W-1:0] r_payload;
    logic                 r_crc_start;

    logic r_out_valid, r_line, r_power_on, r_busy_res, r_load_taken, r_frame_done;
    logic n_line, n_power_on, n_load_taken, n_frame_done;

    logic                 in_accept;
    logic                 is_load;
    t_crc_ctrl            crc_ctrl;
    logic [7:0]           crc;
    logic [BITS_W-1:0]    pos;
    logic [BITS_W-4:0]    byte_idx;
    logic [PAYLOAD_W-1:0] shifted;
    logic [7:0]           byte_val;
    logic                 frame_bit;
    logic [CNT_W-1:0]     gap_dec;
    logic [PULSE_W-1:0]   pulse_dec;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign is_load     = (i_kind == KIND_LOAD) && (r_phase == PH_IDLE);
    assign o_cfg_ready = 1'b1;

    assign crc_ctrl.start   = r_crc_start;
    assign crc_ctrl.payload = r_payload;

    pcft_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (crc_ctrl),
        .o_crc   (crc)
    );

    // next frame bit, MSB first from byte 0 through the CRC byte
    always_comb begin
        pos      = BITS_W'(FRAME_BITS) - r_bits_left;
        byte_idx = pos[BITS_W-1:3];
        shifted  = r_payload >> {byte_idx, 3'b000};
        if (byte_idx >= (BITS_W-3)'(PAYLOAD_BYTES)) begin
            byte_val = crc;
        end else if (int'(byte_idx) < IN_BYTES) begin
            byte_val = shifted[7:0];
        end else begin
            byte_val = 8'h00;
        end
        frame_bit = byte_val[3'd7 - pos[2:0]];
    end

    assign gap_dec   = r_gap_count - 1'b1;
    assign pulse_dec = r_pulses_left - 1'b1;

    always_comb begin
        n_phase       = r_phase;
        n_bits_left   = r_bits_left;
        n_pulses_left = r_pulses_left;
        n_half_high   = r_half_high;
        n_gap_count   = r_gap_count;
        n_line        = 1'b0;
        n_power_on    = 1'b0;
        n_load_taken  = 1'b0;
        n_frame_done  = 1'b0;
        if (i_kind == KIND_LOAD) begin
            n_power_on = 1'b1;
            if (is_load) begin
                n_load_taken = 1'b1;
                n_bits_left  = BITS_W'(FRAME_BITS);
                if (r_lead_ticks == '0) begin
                    n_phase       = PH_BURST;
                    n_pulses_left = (r_start_pulses == '0) ? PULSE_W'(1) : r_start_pulses;
                    n_half_high   = 1'b0;
                end else begin
                    n_phase     = PH_LEAD;
                    n_gap_count = CNT_W'(r_lead_ticks);
                end
            end else begin
                n_line = (r_phase == PH_BURST) && r_half_high;
            end
        end else if (r_phase != PH_IDLE) begin
            n_power_on = 1'b1;
            unique case (r_phase)
                PH_LEAD: begin
                    n_gap_count = gap_dec;
                    if (gap_dec == '0) begin
                        n_phase       = PH_BURST;
                        n_pulses_left = (r_start_pulses == '0) ? PULSE_W'(1) : r_start_pulses;
                        n_half_high   = 1'b0;
                    end
                end
                PH_BURST: begin
                    if (!r_half_high) begin
                        n_line      = 1'b1;
                        n_half_high = 1'b1;
                    end else begin
                        n_half_high   = 1'b0;
                        n_pulses_left = pulse_dec;
                        if (pulse_dec == '0) begin
                            n_phase     = PH_GAP;
                            n_gap_count = (r_gap_ticks == '0) ? CNT_W'(1)
                                                              : CNT_W'(r_gap_ticks);
                        end
                    end
                end
                PH_GAP: begin
                    n_gap_count = gap_dec;
                    if (gap_dec == '0) begin
                        if (r_bits_left != '0) begin
                            n_bits_left = r_bits_left - 1'b1;
                            n_phase     = PH_BURST;
                            n_half_high = 1'b0;
                            if (frame_bit) begin
                                n_pulses_left = (r_one_pulses == '0) ? PULSE_W'(1)
                                                                     : r_one_pulses;
                            end else begin
                                n_pulses_left = (r_zero_pulses == '0) ? PULSE_W'(1)
                                                                      : r_zero_pulses;
                            end
                        end else if (r_tail_ticks == '0) begin
                            n_phase      = PH_IDLE;
                            n_frame_done = 1'b1;
                        end else begin
                            n_phase     = PH_TAIL;
                            n_gap_count = r_tail_ticks;
                        end
                    end
                end
                PH_TAIL: begin
                    n_gap_count = gap_dec;
                    if (gap_dec == '0) begin
                        n_phase      = PH_IDLE;
                        n_frame_done = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pulses <= START_PULSES_RST;
            r_one_pulses   <= ONE_PULSES_RST;
            r_zero_pulses  <= ZERO_PULSES_RST;
            r_gap_ticks    <= GAP_TICKS_RST;
            r_lead_ticks   <= LEAD_TICKS_RST;
            r_tail_ticks   <= TAIL_TICKS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_START_PULSES: r_start_pulses <= i_cfg_data[PULSE_W-1:0];
                REG_ONE_PULSES:   r_one_pulses   <= i_cfg_data[PULSE_W-1:0];
                REG_ZERO_PULSES:  r_zero_pulses  <= i_cfg_data[PULSE_W-1:0];
                REG_GAP_TICKS:    r_gap_ticks    <= i_cfg_data[GAP_W-1:0];
                REG_LEAD_TICKS:   r_lead_ticks   <= i_cfg_data[LEAD_W-1:0];
                REG_TAIL_TICKS:   r_tail_ticks   <= i_cfg_data[TAIL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bits_left   <= '0;
            r_pulses_left <= '0;
            r_half_high   <= 1'b0;
            r_gap_count   <= '0;
            r_crc_start   <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_crc_start <= in_accept && is_load;
            if (in_accept) begin
                r_phase       <= n_phase;
                r_bits_left   <= n_bits_left;
                r_pulses_left <= n_pulses_left;
                r_half_high   <= n_half_high;
                r_gap_count   <= n_gap_count;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && is_load) begin
            r_payload <= i_payload;
        end
        if (in_accept) begin
            r_line       <= n_line;
            r_power_on   <= n_power_on;
            r_busy_res   <= (n_phase != PH_IDLE);
            r_load_taken <= n_load_taken;
            r_frame_done <= n_frame_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line       = r_line;
    assign o_power_on   = r_power_on;
    assign o_busy_res   = r_busy_res;
    assign o_load_taken = r_load_taken;
    assign o_frame_done = r_frame_done;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_power_on && !o_busy_res))
        else $error("frame end reported while still busy");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_load_taken) |-> (o_power_on && o_busy_res && !o_line))
        else $error("accepted load gave a wrong result");

    a_half_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_BURST) |-> !r_half_high)
        else $error("high half outside a burst");

    a_line_needs_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_line) |-> o_power_on)
        else $error("line driven with power off");

endmodule

>>> src/pcft_crc.sv
// pcft_crc: CRC-8 (poly 0x31, init 0xFF, MSB first) over the held payload,
// one byte per clock after a start pulse. Depends on pcft_pkg.
`timescale 1ns / 1ps

module pcft_crc (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcft_pkg::t_crc_ctrl i_ctrl,
    output logic [7:0]          o_crc
);
    import pcft_pkg::*;

    logic [7:0]           r_crc;
    logic [7:0]           n_crc;
    logic [CRC_CNT_W-1:0] r_cnt;
    logic [PAYLOAD_W-1:0] shifted;
    logic [7:0]           data_byte;

    function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] v;
        v = c ^ d;
        for (int i = 0; i < 8; i++) begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

    always_comb begin
        shifted   = i_ctrl.payload >> {r_cnt, 3'b000};
        data_byte = (int'(r_cnt) < IN_BYTES) ? shifted[7:0] : 8'h00;
        n_crc     = crc_byte(r_crc, data_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CRC_CNT_W'(PAYLOAD_BYTES);
            r_crc <= CRC_INIT;
        end else if (i_ctrl.start) begin
            r_cnt <= '0;
            r_crc <= CRC_INIT;
        end else if (r_cnt != CRC_CNT_W'(PAYLOAD_BYTES)) begin
            r_cnt <= r_cnt + 1'b1;
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule
